// ===== rtl/seven_segment_chain_driver_unit_macros.svh =====
// Assertion macros for the seven-segment chain driver checker.
// Depends on nothing; included by the checker file only.
`ifndef SEVEN_SEGMENT_CHAIN_DRIVER_UNIT_MACROS_SVH
`define SEVEN_SEGMENT_CHAIN_DRIVER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SSCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sscd assertion failed");

// next-cycle implication, disabled in reset
`define SSCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sscd assertion failed");

`endif

// ===== rtl/sscd_pkg.sv =====
// Shared types, codes and the digit decode for the seven-segment chain driver.
// No dependencies.
package sscd_pkg;

    localparam logic [1:0] MODE_SET     = 2'd0;
    localparam logic [1:0] MODE_BLANK   = 2'd1;
    localparam logic [1:0] MODE_REFRESH = 2'd2;

    localparam int BITS_PER_DISPLAY = 8;
    localparam int BIT_W            = 3;
    localparam int QUEUE_DEPTH      = 2;
    localparam int PTR_W            = 1;
    localparam int CNT_W            = 2;

    localparam logic [7:0] BLANK_PATTERN = 8'h00;
    localparam logic [7:0] DP_BIT        = 8'h01;

    localparam logic [7:0] DIGIT_PATTERNS [10] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hE6
    };

    // one classified command headed for the back end
    typedef struct packed {
        logic       refresh;
        logic [2:0] position;
        logic [7:0] pattern;
    } cmd_t;

    function automatic logic [7:0] decode_digit(input logic [3:0] digit, input logic dp);
        logic [7:0] pat;
        pat = BLANK_PATTERN;
        if (digit < 4'd10)
        begin
            pat = DIGIT_PATTERNS[digit];
        end
        if (dp)
        begin
            pat = pat | DP_BIT;
        end
        return pat;
    endfunction

endpackage

// ===== rtl/sscd_front.sv =====
// Front end: accepts input transactions, decodes digits and drops no-op items.
// Depends on sscd_pkg.
module sscd_front #(
    parameter int DISPLAYS = 4
) (
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          mode,
    input  logic [2:0]          position,
    input  logic [3:0]          digit,
    input  logic                point,
    input  logic                q_full,
    output logic                push,
    output sscd_pkg::cmd_t      push_cmd
);

    logic in_range;
    logic keep;

    assign in_range = (int'(position) < DISPLAYS);
    assign in_stall = q_full;

    always_comb
    begin
        push_cmd.refresh  = 1'b0;
        push_cmd.position = position;
        push_cmd.pattern  = sscd_pkg::BLANK_PATTERN;
        keep              = 1'b0;
        unique case (mode)
            sscd_pkg::MODE_SET:
            begin
                push_cmd.pattern = sscd_pkg::decode_digit(digit, point);
                keep             = in_range;
            end
            sscd_pkg::MODE_BLANK:
            begin
                keep = in_range;
            end
            sscd_pkg::MODE_REFRESH:
            begin
                push_cmd.refresh = 1'b1;
                keep             = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // out-of-range and unused-mode items are accepted and discarded
    assign push = in_valid && !q_full && keep;

endmodule

// ===== rtl/sscd_queue.sv =====
// Two-entry command queue between front and back end.
// Depends on sscd_pkg.
module sscd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sscd_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output sscd_pkg::cmd_t  pop_cmd
);

    sscd_pkg::cmd_t                  entries_reg [sscd_pkg::QUEUE_DEPTH];
    logic [sscd_pkg::PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [sscd_pkg::PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [sscd_pkg::CNT_W-1:0]      count_reg, count_next;

    assign full      = (count_reg == sscd_pkg::CNT_W'(sscd_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/sscd_back.sv =====
// Back end: holds the segment patterns, applies writes and serializes refreshes.
// Depends on sscd_pkg.
module sscd_back #(
    parameter int DISPLAYS = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_not_empty,
    input  sscd_pkg::cmd_t  q_cmd,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            serial_bit,
    output logic            shift_pulse,
    output logic            latch_pulse,
    output logic            last
);

    localparam int DISP_W = (DISPLAYS > 1) ? $clog2(DISPLAYS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_LATCH = 2'd2;

    logic [7:0]                      patterns_reg [DISPLAYS];
    logic [1:0]                      state_reg, state_next;
    logic [DISP_W-1:0]               disp_reg, disp_next;
    logic [sscd_pkg::BIT_W-1:0]      bit_reg, bit_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            serial_bit_reg, serial_bit_next;
    logic                            shift_reg, shift_next;
    logic                            latch_reg, latch_next;
    logic                            out_free;
    logic                            wr_en;

    assign out_free    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign serial_bit  = serial_bit_reg;
    assign shift_pulse = shift_reg;
    assign latch_pulse = latch_reg;
    assign last        = latch_reg;

    always_comb
    begin
        state_next      = state_reg;
        disp_next       = disp_reg;
        bit_next        = bit_reg;
        out_valid_next  = out_valid_reg && out_stall;
        serial_bit_next = serial_bit_reg;
        shift_next      = shift_reg;
        latch_next      = latch_reg;
        pop             = 1'b0;
        wr_en           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    pop = 1'b1;
                    if (q_cmd.refresh)
                    begin
                        state_next = ST_SHIFT;
                        disp_next  = DISP_W'(DISPLAYS - 1);
                        bit_next   = '0;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    serial_bit_next = patterns_reg[disp_reg][bit_reg];
                    shift_next      = 1'b1;
                    latch_next      = 1'b0;
                    bit_next        = bit_reg + 1'b1;
                    // last display first, LSB first within a display
                    if (bit_reg == sscd_pkg::BIT_W'(sscd_pkg::BITS_PER_DISPLAY - 1))
                    begin
                        if (disp_reg == '0)
                        begin
                            state_next = ST_LATCH;
                        end
                        else
                        begin
                            disp_next = disp_reg - 1'b1;
                        end
                    end
                end
            end
            ST_LATCH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    serial_bit_next = 1'b0;
                    shift_next      = 1'b0;
                    latch_next      = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            disp_reg      <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            disp_reg      <= disp_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        serial_bit_reg <= serial_bit_next;
        shift_reg      <= shift_next;
        latch_reg      <= latch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DISPLAYS; i++)
            begin
                patterns_reg[i] <= sscd_pkg::BLANK_PATTERN;
            end
        end
        else if (wr_en)
        begin
            patterns_reg[q_cmd.position[DISP_W-1:0]] <= q_cmd.pattern;
        end
    end

endmodule

// ===== rtl/seven_segment_chain_driver_unit.sv =====
// Channel   Handshake            Payload
// in        in_valid / in_stall  mode, position, digit, point
// out       out_valid/ out_stall serial_bit, shift_pulse, latch_pulse, last
//
// Set and blank transactions give no result.
// A refresh dequeues its command, then the single serializer gives DISPLAYS*8
// shift results and one latch result.
// Reset clears all segment patterns to blank and empties the command queue.
// A two-entry queue lets input transactions be taken while a refresh runs;
// in_stall rises only when it is full. out_stall freezes the serializer.
// Top level: front end, command queue and back end. Depends on sscd_pkg,
// sscd_front, sscd_queue and sscd_back.
module seven_segment_chain_driver_unit #(
    parameter int DISPLAYS = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [2:0] position,
    input  logic [3:0] digit,
    input  logic       point,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       serial_bit,
    output logic       shift_pulse,
    output logic       latch_pulse,
    output logic       last
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_not_empty;
    sscd_pkg::cmd_t push_cmd;
    sscd_pkg::cmd_t pop_cmd;

    sscd_front #(
        .DISPLAYS (DISPLAYS)
    ) u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .position      (position),
        .digit         (digit),
        .point         (point),
        .q_full        (q_full),
        .push          (q_push),
        .push_cmd      (push_cmd)
    );

    sscd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cmd   (pop_cmd)
    );

    sscd_back #(
        .DISPLAYS (DISPLAYS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_cmd       (pop_cmd),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .serial_bit  (serial_bit),
        .shift_pulse (shift_pulse),
        .latch_pulse (latch_pulse),
        .last        (last)
    );

endmodule

// ===== rtl/sscd_checker.sv =====
// Port-level checks on the seven-segment chain driver, bound to the top level.
// Depends on seven_segment_chain_driver_unit_macros.svh.
`include "seven_segment_chain_driver_unit_macros.svh"

module sscd_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic serial_bit,
    input logic shift_pulse,
    input logic latch_pulse,
    input logic last
);

    // a stalled result transaction holds
    `SSCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(serial_bit) && $stable(shift_pulse) && $stable(latch_pulse))
    // every result is exactly one kind of pulse
    `SSCD_ASSERT_NOW(a_one_kind, clk, rst_n, out_valid, shift_pulse != latch_pulse)
    // a run ends on the latch and only there
    `SSCD_ASSERT_NOW(a_last_latch, clk, rst_n, out_valid, last == latch_pulse)
    // data line low on the latch
    `SSCD_ASSERT_NOW(a_latch_zero, clk, rst_n, out_valid && latch_pulse, !serial_bit)

endmodule

bind seven_segment_chain_driver_unit sscd_checker u_sscd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .serial_bit  (serial_bit),
    .shift_pulse (shift_pulse),
    .latch_pulse (latch_pulse),
    .last        (last)
);

// ===== tb/seven_segment_chain_driver_unit_tb.sv =====
// Self-checking testbench for seven_segment_chain_driver_unit: directed table, then random traffic.
// Keeps a shadow copy of the segment patterns and predicts every shift and latch result.
// Depends on sscd_pkg and the RTL top level only.
`timescale 1ns / 100ps

module seven_segment_chain_driver_unit_tb;

    localparam int DISPLAYS       = 4;
    localparam int CHAIN_W        = DISPLAYS * sscd_pkg::BITS_PER_DISPLAY;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 140;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = DISPLAYS * sscd_pkg::BITS_PER_DISPLAY + 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic serial_bit;
        logic shift_pulse;
        logic latch_pulse;
        logic last;
    } chain_beat_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [2:0]         position;
        logic [3:0]         digit;
        logic               dp;
        logic               typed;
        logic [CHAIN_W-1:0] chain;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] mode;
    logic [2:0] position;
    logic [3:0] digit;
    logic       point;
    logic       out_valid;
    logic       out_stall;
    logic       serial_bit;
    logic       shift_pulse;
    logic       latch_pulse;
    logic       last;

    // typed-in chain image that travels with the transaction on the input side
    logic               cur_typed;
    logic [CHAIN_W-1:0] cur_chain;

    logic [7:0]  shadow_patterns [DISPLAYS];
    chain_beat_t pending_beats [$];

    int failures;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    bit hold_request;
    int idle_cycles;

    stim_row_t directed_rows [25];

    seven_segment_chain_driver_unit #(
        .DISPLAYS(DISPLAYS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .position(position),
        .digit(digit),
        .point(point),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .serial_bit(serial_bit),
        .shift_pulse(shift_pulse),
        .latch_pulse(latch_pulse),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] segments_for(input logic [3:0] d, input logic dp);
        logic [7:0] pat;
        case (d)
            4'd0:    pat = 8'hFC;
            4'd1:    pat = 8'h60;
            4'd2:    pat = 8'hDA;
            4'd3:    pat = 8'hF2;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'hB6;
            4'd6:    pat = 8'hBE;
            4'd7:    pat = 8'hE0;
            4'd8:    pat = 8'hFE;
            4'd9:    pat = 8'hE6;
            default: pat = 8'h00;
        endcase
        return dp ? (pat | 8'h01) : pat;
    endfunction

    // last display goes out first, each pattern LSB first, then the latch
    task automatic queue_chain_shift(input logic [CHAIN_W-1:0] chain);
        for (int d = DISPLAYS - 1; d >= 0; d--)
        begin
            for (int b = 0; b < sscd_pkg::BITS_PER_DISPLAY; b++)
            begin
                pending_beats.push_back('{chain[d * sscd_pkg::BITS_PER_DISPLAY + b],
                                          1'b1, 1'b0, 1'b0});
            end
        end
        pending_beats.push_back('{1'b0, 1'b0, 1'b1, 1'b1});
    endtask

    task automatic apply_transaction(input logic [1:0] m, input logic [2:0] pos,
                                     input logic [3:0] d, input logic dp,
                                     input logic typed, input logic [CHAIN_W-1:0] chain);
        logic [CHAIN_W-1:0] image;
        case (m)
            sscd_pkg::MODE_SET:
            begin
                if (pos < DISPLAYS)
                    shadow_patterns[pos] = segments_for(d, dp);
            end
            sscd_pkg::MODE_BLANK:
            begin
                if (pos < DISPLAYS)
                    shadow_patterns[pos] = 8'h00;
            end
            sscd_pkg::MODE_REFRESH:
            begin
                for (int i = 0; i < DISPLAYS; i++)
                    image[i * sscd_pkg::BITS_PER_DISPLAY +: sscd_pkg::BITS_PER_DISPLAY] =
                        shadow_patterns[i];
                queue_chain_shift(typed ? chain : image);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_beat();
        chain_beat_t got;
        chain_beat_t want;
        got = '{serial_bit, shift_pulse, latch_pulse, last};
        if (pending_beats.size() == 0)
        begin
            if (failures < REPORT_LIMIT)
                $display("unexpected result: bit=%0b shift=%0b latch=%0b last=%0b",
                         got.serial_bit, got.shift_pulse, got.latch_pulse, got.last);
            failures++;
        end
        else
        begin
            want = pending_beats.pop_front();
            if (got.serial_bit !== want.serial_bit || got.shift_pulse !== want.shift_pulse ||
                got.latch_pulse !== want.latch_pulse || got.last !== want.last)
            begin
                if (failures < REPORT_LIMIT)
                    $display("mismatch at %0t: exp bit=%0b shift=%0b latch=%0b last=%0b,",
                             $realtime, want.serial_bit, want.shift_pulse,
                             want.latch_pulse, want.last,
                             " got bit=%0b shift=%0b latch=%0b last=%0b",
                             got.serial_bit, got.shift_pulse, got.latch_pulse, got.last);
                failures++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_beat();
            if (in_valid && !in_stall)
                apply_transaction(mode, position, digit, point, cur_typed, cur_chain);
        end
    end

    // cycles with neither channel moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic drive_item(input stim_row_t row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        mode          <= row.mode;
        position      <= row.position;
        digit         <= row.digit;
        point         <= row.dp;
        cur_typed     <= row.typed;
        cur_chain     <= row.chain;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic stim_row_t random_row();
        stim_row_t row;
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            row.mode = sscd_pkg::MODE_SET;
        else if (pick < 63)
            row.mode = sscd_pkg::MODE_BLANK;
        else if (pick < 93)
            row.mode = sscd_pkg::MODE_REFRESH;
        else
            row.mode = MODE_UNUSED;
        if ($urandom_range(99) < 80)
            row.position = 3'($urandom_range(DISPLAYS - 1));
        else
            row.position = 3'($urandom_range(7, DISPLAYS));
        row.digit = 4'($urandom_range(15));
        row.dp    = 1'($urandom_range(1));
        row.typed = 1'b0;
        row.chain = '0;
        return row;
    endfunction

    initial
    begin
        stim_row_t row;
        int counted;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = sscd_pkg::MODE_SET;
        position      = 3'd0;
        digit         = 4'd0;
        point         = 1'b0;
        cur_typed     = 1'b0;
        cur_chain     = '0;
        failures      = 0;
        idle_cycles   = 0;
        hold_request  = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < DISPLAYS; i++)
            shadow_patterns[i] = 8'h00;

        directed_rows = '{
            '{sscd_pkg::MODE_REFRESH, 3'd0, 4'd0,  1'b0, 1'b1, 32'h00000000},  // blank after reset
            '{sscd_pkg::MODE_SET,     3'd0, 4'd0,  1'b0, 1'b0, 32'h0},
            '{sscd_pkg::MODE_SET,     3'd1, 4'd9,  1'b1, 1'b0, 32'h0},
            '{sscd_pkg::MODE_SET,     3'd2, 4'd15, 1'b0, 1'b0, 32'h0},  // above nine: blank
            '{sscd_pkg::MODE_SET,     3'd3, 4'd10, 1'b1, 1'b0, 32'h0},  // blank plus point
            '{sscd_pkg::MODE_REFRESH, 3'd7, 4'd15, 1'b1, 1'b1, 32'h0100E7FC},
            '{sscd_pkg::MODE_SET,     3'd4, 4'd8,  1'b1, 1'b0, 32'h0},  // off the chain
            '{sscd_pkg::MODE_BLANK,   3'd7, 4'd0,  1'b0, 1'b0, 32'h0},  // off the chain
            '{MODE_UNUSED,            3'd0, 4'd8,  1'b1, 1'b0, 32'h0},  // ignored mode
            '{sscd_pkg::MODE_REFRESH, 3'd0, 4'd0,  1'b0, 1'b1, 32'h0100E7FC},
            '{sscd_pkg::MODE_SET,     3'd0, 4'd8,  1'b1, 1'b0, 32'h0},
            '{sscd_pkg::MODE_SET,     3'd1, 4'd8,  1'b1, 1'b0, 32'h0},
            '{sscd_pkg::MODE_SET,     3'd2, 4'd8,  1'b1, 1'b0, 32'h0},
            '{sscd_pkg::MODE_SET,     3'd3, 4'd8,  1'b1, 1'b0, 32'h0},
            '{sscd_pkg::MODE_REFRESH, 3'd0, 4'd0,  1'b0, 1'b1, 32'hFFFFFFFF},
            '{sscd_pkg::MODE_BLANK,   3'd0, 4'd0,  1'b0, 1'b0, 32'h0},
            '{sscd_pkg::MODE_SET,     3'd1, 4'd1,  1'b0, 1'b0, 32'h0},
            '{sscd_pkg::MODE_SET,     3'd2, 4'd2,  1'b1, 1'b0, 32'h0},
            '{sscd_pkg::MODE_SET,     3'd3, 4'd4,  1'b0, 1'b0, 32'h0},
            '{sscd_pkg::MODE_REFRESH, 3'd0, 4'd0,  1'b0, 1'b0, 32'h0},
            '{sscd_pkg::MODE_SET,     3'd0, 4'd3,  1'b0, 1'b0, 32'h0},
            '{sscd_pkg::MODE_SET,     3'd1, 4'd5,  1'b1, 1'b0, 32'h0},
            '{sscd_pkg::MODE_SET,     3'd2, 4'd6,  1'b0, 1'b0, 32'h0},
            '{sscd_pkg::MODE_SET,     3'd3, 4'd7,  1'b1, 1'b0, 32'h0},
            '{sscd_pkg::MODE_REFRESH, 3'd0, 4'd0,  1'b0, 1'b0, 32'h0}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            drive_item(directed_rows[i]);

        // fill the queue while the receiver holds off
        hold_request = 1'b1;
        for (int i = 0; i < 5; i++)
        begin
            row = random_row();
            row.mode = sscd_pkg::MODE_REFRESH;
            drive_item(row);
        end

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            case (counted * 4 / RANDOM_ITEMS)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 56;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 56;
                end
                default:
                begin
                    send_idle_pct = 9;
                    recv_stall_pct = 9;
                end
            endcase
            row = random_row();
            drive_item(row);
            counted++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
